>>> rtl/utf32_text_encoder_crlf_core_defines.svh
// assertion macros shared by the encoder checker
`ifndef UTF32_TEXT_ENCODER_CRLF_CORE_DEFINES_SVH
`define UTF32_TEXT_ENCODER_CRLF_CORE_DEFINES_SVH

// concurrent assertion on the block clock, off while reset is held
`define U32ENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, written as an implication in the same cycle
`define U32ENC_ASSERT_IMPL(label, ante, cons, msg) \
  `U32ENC_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/u32enc_pkg.sv
// types and constants shared by the encoder modules
package u32enc_pkg;

  // output encoding codes; the unused code behaves as utf-8
  localparam logic [1:0] ModeUtf8    = 2'd0;
  localparam logic [1:0] ModeUtf16Le = 2'd1;
  localparam logic [1:0] ModeUtf16Be = 2'd2;

  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [7:0]  CharLf      = 8'h0A;
  localparam logic [20:0] ReplChar    = 21'h00FFFD;
  localparam logic [20:0] MaxCodePt   = 21'h10FFFF;

  // one input item held in the input register
  typedef struct packed {
    logic [20:0] code_point;
    logic        string_start;
  } item_t;

  // encoded result plus the next carriage-return memory
  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic        cr_next;
  } result_t;

endpackage

>>> rtl/utf32_text_encoder_crlf_core.sv
// top level of the utf-32 to utf-8 / utf-16 text encoder
// Takes one code point per item and returns one item of 1 to 4 encoded bytes, first byte
// lowest. The block accepts one item every cycle when the output side is ready; each item
// passes an input register, one level of encode logic and a result register in that order,
// and a result is held in the result register until it is taken. A lone line feed is
// written as cr lf; the carriage-return memory is set only by a carriage return, is cleared
// by every other item and is ignored for an item that carries string_start.
// Invalid code points come out as U+FFFD. The encoding register should be written only
// while no item is in flight.
module utf32_text_encoder_crlf_core
  import u32enc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // encoding select: 0 utf-8, 1 utf-16 le, 2 utf-16 be
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // code_point [20:0], zero pad [23:21]
  input  logic        s_axis_tuser_i,   // string_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // out_bytes [31:0], byte_count [34:32], pad [39:35]
);

  logic [1:0]  mode_q;
  item_t       in_item;
  item_t       held_item;
  logic        held_valid;
  logic        out_ready;
  logic        cr_q;
  result_t     result;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;

  // encoding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeUtf8;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign in_item.code_point   = s_axis_tdata_i[20:0];
  assign in_item.string_start = s_axis_tuser_i;

  u32enc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .down_ready_i (out_ready),
    .valid_o      (held_valid),
    .item_o       (held_item)
  );

  u32enc_encode u_encode (
    .item_i   (held_item),
    .mode_i   (mode_q),
    .cr_i     (cr_q),
    .result_o (result)
  );

  u32enc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (held_valid),
    .up_ready_o   (out_ready),
    .result_i     (result),
    .cr_o         (cr_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_bytes_o  (out_bytes),
    .byte_count_o (byte_count)
  );

  assign m_axis_tdata_o = {5'd0, byte_count, out_bytes};

endmodule

>>> rtl/u32enc_in_stage.sv
// input register stage of the encoder
module u32enc_in_stage
  import u32enc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  down_ready_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // take a new item when the register is empty or the held one moves on this cycle
  assign in_ready_o = !valid_q || down_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/u32enc_encode.sv
// combinational utf-8 / utf-16 encoder with lf to cr lf expansion
module u32enc_encode
  import u32enc_pkg::*;
(
  input  item_t      item_i,
  input  logic [1:0] mode_i,
  input  logic       cr_i,
  output result_t    result_o
);

  // one 16-bit unit in stream order, byte swapped for big endian
  function automatic logic [15:0] pack16(input logic [15:0] unit, input logic be);
    pack16 = be ? {unit[7:0], unit[15:8]} : unit;
  endfunction

  logic [20:0] cp;
  logic        bad;
  logic        utf16;
  logic        be;
  logic        cr_eff;
  logic        single;
  logic        is_lf;
  logic        is_cr;
  logic [20:0] v_full;
  logic [19:0] v;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  // replace surrogates and out-of-range values
  assign bad = (item_i.code_point > MaxCodePt) ||
               (item_i.code_point[20:11] == 10'h01B);
  assign cp  = bad ? ReplChar : item_i.code_point;

  assign utf16  = (mode_i == ModeUtf16Le) || (mode_i == ModeUtf16Be);
  assign be     = (mode_i == ModeUtf16Be);
  assign cr_eff = cr_i && !item_i.string_start;
  assign single = utf16 ? (cp < 21'h010000) : (cp < 21'h000080);
  assign is_lf  = (cp == {13'd0, CharLf});
  assign is_cr  = (cp == {13'd0, CharCr});

  // surrogate pair halves
  assign v_full  = cp - 21'h010000;
  assign v       = v_full[19:0];
  assign hi_unit = {6'b110110, v[19:10]};
  assign lo_unit = {6'b110111, v[9:0]};

  always_comb begin
    result_o.out_bytes  = 32'd0;
    result_o.byte_count = 3'd1;
    result_o.cr_next    = 1'b0;
    if (single) begin
      if (is_lf && !cr_eff) begin
        // lone line feed becomes cr lf, memory cleared
        result_o.cr_next = cr_eff;
        if (utf16) begin
          result_o.out_bytes  = {pack16({8'd0, CharLf}, be), pack16({8'd0, CharCr}, be)};
          result_o.byte_count = 3'd4;
        end else begin
          result_o.out_bytes  = {16'd0, CharLf, CharCr};
          result_o.byte_count = 3'd2;
        end
      end else begin
        result_o.cr_next = is_cr;
        if (utf16) begin
          result_o.out_bytes  = {16'd0, pack16(cp[15:0], be)};
          result_o.byte_count = 3'd2;
        end else begin
          result_o.out_bytes  = {24'd0, 1'b0, cp[6:0]};
          result_o.byte_count = 3'd1;
        end
      end
    end else if (utf16) begin
      result_o.out_bytes  = {pack16(lo_unit, be), pack16(hi_unit, be)};
      result_o.byte_count = 3'd4;
    end else if (cp < 21'h000800) begin
      result_o.out_bytes  = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      result_o.byte_count = 3'd2;
    end else if (cp < 21'h010000) begin
      result_o.out_bytes  = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      result_o.byte_count = 3'd3;
    end else begin
      result_o.out_bytes  = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                             5'b11110, cp[20:18]};
      result_o.byte_count = 3'd4;
    end
  end

endmodule

>>> rtl/u32enc_out_stage.sv
// result register stage and carriage-return memory
module u32enc_out_stage
  import u32enc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        up_valid_i,
  output logic        up_ready_o,
  input  result_t     result_i,
  output logic        cr_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_bytes_o,
  output logic [2:0]  byte_count_o
);

  logic        valid_q, valid_d;
  logic        cr_q, cr_d;
  logic [31:0] bytes_q;
  logic [2:0]  count_q;
  logic        load;

  // the register frees up when empty or when its item is taken
  assign up_ready_o = !valid_q || out_ready_i;
  assign load       = up_valid_i && up_ready_o;

  always_comb begin
    valid_d = valid_q;
    cr_d    = cr_q;
    if (load) begin
      valid_d = 1'b1;
      cr_d    = result_i.cr_next;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cr_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cr_q    <= cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= result_i.out_bytes;
      count_q <= result_i.byte_count;
    end
  end

  assign cr_o         = cr_q;
  assign out_valid_o  = valid_q;
  assign out_bytes_o  = bytes_q;
  assign byte_count_o = count_q;

endmodule

>>> rtl/u32enc_checker.sv
// port-level checks for the encoder, bound to the top level
`include "utf32_text_encoder_crlf_core_defines.svh"

module u32enc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_wdata_i,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  logic [2:0] cnt;
  assign cnt = m_axis_tdata_o[34:32];

  // a result always carries one to four bytes
  `U32ENC_ASSERT_IMPL(a_count_range, m_axis_tvalid_o, (cnt >= 3'd1) && (cnt <= 3'd4),
                      "byte count out of range")

  // bytes past the count are zero
  `U32ENC_ASSERT_IMPL(a_unused_zero, m_axis_tvalid_o,
                      (cnt == 3'd4) ||
                      ((cnt == 3'd3) && (m_axis_tdata_o[31:24] == 8'd0)) ||
                      ((cnt == 3'd2) && (m_axis_tdata_o[31:16] == 16'd0)) ||
                      ((cnt == 3'd1) && (m_axis_tdata_o[31:8] == 24'd0)),
                      "stray byte beyond count")

  // input side never stalls while the output side takes results
  `U32ENC_ASSERT_IMPL(a_full_rate, m_axis_tready_i, s_axis_tready_o,
                      "input stalled with output ready")

  // a stalled result holds
  `U32ENC_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=>
                 (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled result changed")

endmodule

bind utf32_text_encoder_crlf_core u32enc_checker u_checker (.*);
